@@ design/line_rasterizer_top_defines.svh @@
// Assertion macros shared by the line rasterizer checkers.
`ifndef LINE_RASTERIZER_TOP_DEFINES_SVH
`define LINE_RASTERIZER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define LR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define LR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/lr_pkg.sv @@
// Types and constants shared by the line rasterizer modules.
`default_nettype none

package lr_pkg;

  localparam int unsigned COORD_W   = 6;
  localparam int unsigned COLOUR_W  = 8;
  localparam int unsigned CFG_W     = 7;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned ERR_W     = 9;
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] PLANE_RESET = 7'd64;

  typedef enum logic {
    LR_IDLE,
    LR_EMIT
  } lr_state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic step;
  } lr_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last;
  } lr_status_t;

endpackage

`default_nettype wire

@@ design/lr_ctrl.sv @@
// Line rasterizer controller: command load and pixel sequencing FSM.
`default_nettype none

module lr_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  input  wire lr_pkg::lr_status_t status_i,
  output lr_pkg::lr_cmd_t     cmd_o
);

  lr_pkg::lr_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lr_pkg::LR_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      lr_pkg::LR_IDLE: begin
        if (in_valid_i) state_d = lr_pkg::LR_EMIT;
      end
      lr_pkg::LR_EMIT: begin
        if (out_ready_i && status_i.last) state_d = lr_pkg::LR_IDLE;
      end
      default: state_d = lr_pkg::LR_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      lr_pkg::LR_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      lr_pkg::LR_EMIT: begin
        out_valid_o = 1'b1;
        cmd_o.step  = out_ready_i && !status_i.last;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ design/lr_datapath.sv @@
// Line rasterizer datapath: setup, Bresenham step and plane clipping.
`default_nettype none

module lr_datapath #(
  parameter int unsigned PLANE_SIZE = 64
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [lr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [lr_pkg::CFG_W-1:0]      cfg_data_i,
  input  wire lr_pkg::lr_cmd_t               cmd_i,
  output lr_pkg::lr_status_t                 status_o,
  input  wire logic [lr_pkg::COORD_W-1:0]    start_x_i,
  input  wire logic [lr_pkg::COORD_W-1:0]    start_y_i,
  input  wire logic [lr_pkg::COORD_W-1:0]    end_x_i,
  input  wire logic [lr_pkg::COORD_W-1:0]    end_y_i,
  input  wire logic [lr_pkg::COLOUR_W-1:0]   colour_i,
  output logic [lr_pkg::COORD_W-1:0]         pixel_x_o,
  output logic [lr_pkg::COORD_W-1:0]         pixel_y_o,
  output logic [lr_pkg::COLOUR_W-1:0]        pixel_colour_o,
  output logic                               inside_res_o
);

  localparam int unsigned CW    = lr_pkg::COORD_W;
  localparam int unsigned EW    = lr_pkg::ERR_W;
  localparam int unsigned REM_W = $clog2(PLANE_SIZE);
  localparam logic [CW:0] REM_MAX = (CW+1)'(PLANE_SIZE - 1);

  logic [lr_pkg::CFG_W-1:0] plane_w_q, plane_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_w_q <= lr_pkg::PLANE_RESET;
      plane_h_q <= lr_pkg::PLANE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lr_pkg::CFG_PLANE_WIDTH:  plane_w_q <= cfg_data_i;
        lr_pkg::CFG_PLANE_HEIGHT: plane_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // setup
  logic [CW-1:0] dx, dy, a0, b0, a1, b1, dmaj, dmin;
  logic          steep;
  logic [CW:0]   rem_full;

  always_comb begin
    dx    = (end_x_i > start_x_i) ? end_x_i - start_x_i : start_x_i - end_x_i;
    dy    = (end_y_i > start_y_i) ? end_y_i - start_y_i : start_y_i - end_y_i;
    steep = dy > dx;
    a0    = steep ? start_y_i : start_x_i;
    b0    = steep ? start_x_i : start_y_i;
    a1    = steep ? end_y_i   : end_x_i;
    b1    = steep ? end_x_i   : end_y_i;
    dmaj  = steep ? dy : dx;
    dmin  = steep ? dx : dy;
    rem_full = ({1'b0, dmaj} > REM_MAX) ? REM_MAX : {1'b0, dmaj};
  end

  // walk registers
  logic [CW-1:0]              a_q, b_q, dmaj_q, dmin_q;
  logic signed [EW-1:0]       err_q;
  logic [REM_W-1:0]           rem_q;
  logic                       steep_q, a_up_q, b_up_q;
  logic [lr_pkg::COLOUR_W-1:0] colour_q;

  logic signed [EW-1:0] e_sum, e_next;
  logic signed [EW:0]   twice_e, dmaj_ext;
  logic                 b_move;

  always_comb begin
    e_sum    = err_q + $signed({{(EW-CW){1'b0}}, dmin_q});
    twice_e  = $signed({e_sum, 1'b0});
    dmaj_ext = $signed({{(EW+1-CW){1'b0}}, dmaj_q});
    b_move   = twice_e > dmaj_ext;
    e_next   = b_move ? e_sum - $signed({{(EW-CW){1'b0}}, dmaj_q}) : e_sum;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      a_q      <= a0;
      b_q      <= b0;
      err_q    <= '0;
      rem_q    <= rem_full[REM_W-1:0];
      steep_q  <= steep;
      a_up_q   <= a0 < a1;
      b_up_q   <= b0 < b1;
      dmaj_q   <= dmaj;
      dmin_q   <= dmin;
      colour_q <= colour_i;
    end else if (cmd_i.step) begin
      a_q   <= a_up_q ? a_q + 1'b1 : a_q - 1'b1;
      if (b_move) b_q <= b_up_q ? b_q + 1'b1 : b_q - 1'b1;
      err_q <= e_next;
      rem_q <= rem_q - 1'b1;
    end
  end

  assign status_o.last  = (rem_q == '0);
  assign pixel_x_o      = steep_q ? b_q : a_q;
  assign pixel_y_o      = steep_q ? a_q : b_q;
  assign pixel_colour_o = colour_q;
  assign inside_res_o   = ({1'b0, pixel_x_o} < plane_w_q) && ({1'b0, pixel_y_o} < plane_h_q);

endmodule

`default_nettype wire

@@ design/line_rasterizer_top.sv @@
// Line rasterizer top level: Bresenham line pixel generator with plane clipping.
// First pixel: the edge that accepts a command loads the walk registers, which
//   then drive its first pixel beat. Throughput: min(major delta + 1, PLANE_SIZE)
//   pixels at one per cycle while m_axis_tready is high, set by the lr_datapath
//   step loop; the next command is taken only once the FSM is back in idle.
// Reset: asynchronous, active low; FSM returns idle, plane width/height to 64.
`default_nettype none

module line_rasterizer_top #(
  parameter int unsigned PLANE_SIZE = 64  // pixel cap per line, 2..64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write port
  input  wire logic                         cfg_we_i,
  input  wire logic [lr_pkg::CFG_IDX_W-1:0] cfg_idx_i,   // 0: plane_width, 1: plane_height
  input  wire logic [lr_pkg::CFG_W-1:0]     cfg_data_i,
  // line command stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // start_x[5:0], start_y[11:6], end_x[17:12], end_y[23:18], colour[31:24]
  input  wire logic [lr_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // pixel stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // pixel_x[5:0], pixel_y[11:6], pixel_colour[19:12], zero pad[23:20]
  output logic [lr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic [0:0]       m_axis_tuser,               // inside_res[0]
  output logic             m_axis_tlast                // final pixel of line
);

  lr_pkg::lr_cmd_t    cmd;
  lr_pkg::lr_status_t status;

  logic [lr_pkg::COORD_W-1:0]  pixel_x, pixel_y;
  logic [lr_pkg::COLOUR_W-1:0] pixel_colour;
  logic                        inside_res;

  // FSM: idle takes one command beat, emit walks the line
  lr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // current pixel is held in the walk registers until its beat is taken
  lr_datapath #(
    .PLANE_SIZE (PLANE_SIZE)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .start_x_i      (s_axis_tdata[5:0]),
    .start_y_i      (s_axis_tdata[11:6]),
    .end_x_i        (s_axis_tdata[17:12]),
    .end_y_i        (s_axis_tdata[23:18]),
    .colour_i       (s_axis_tdata[31:24]),
    .pixel_x_o      (pixel_x),
    .pixel_y_o      (pixel_y),
    .pixel_colour_o (pixel_colour),
    .inside_res_o   (inside_res)
  );

  assign m_axis_tdata = {4'b0000, pixel_colour, pixel_y, pixel_x};
  assign m_axis_tuser = inside_res;
  assign m_axis_tlast = status.last;

endmodule

`default_nettype wire

@@ design/lr_checker.sv @@
// Port-level checks for the line rasterizer, bound to the top level.
`default_nettype none
`include "line_rasterizer_top_defines.svh"

module lr_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata,
  input wire logic        m_axis_tlast
);

  logic in_beat, out_beat;
  assign in_beat  = s_axis_tvalid && s_axis_tready;
  assign out_beat = m_axis_tvalid && m_axis_tready;

  `LR_ASSERT_NEXT(a_stall_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "pixel changed while stalled")
  `LR_ASSERT_NOW(a_no_overlap, in_beat, !m_axis_tvalid, "command taken while a line is active")
  `LR_ASSERT_NEXT(a_first_pixel, in_beat, m_axis_tvalid, "no pixel after command")
  `LR_ASSERT_NEXT(a_line_end, out_beat && m_axis_tlast, !m_axis_tvalid && s_axis_tready, "pixel after last beat")

endmodule

bind line_rasterizer_top lr_checker u_lr_checker (.*);

`default_nettype wire

@@ tb/tb_line_rasterizer_top.sv @@
// Self-checking testbench for the Bresenham line rasterizer top level.
`timescale 1ns / 1ps

module tb_line_rasterizer_top;

  localparam int unsigned PIXEL_CAP   = 64;         // DUT PLANE_SIZE
  localparam int unsigned CYCLE_LIMIT = 1_500_000;  // hard stop for a hung run
  localparam int unsigned LONG_HOLD   = 400;        // receiver back-pressure stretch
  localparam int unsigned PHASE_LINES = 50;         // random lines per config phase

  // Command beat layout, lowest bits first: start_x, start_y, end_x, end_y, colour.
  typedef struct packed {
    logic [lr_pkg::COLOUR_W-1:0] colour;
    logic [lr_pkg::COORD_W-1:0]  ey;
    logic [lr_pkg::COORD_W-1:0]  ex;
    logic [lr_pkg::COORD_W-1:0]  sy;
    logic [lr_pkg::COORD_W-1:0]  sx;
  } line_cmd_t;

  typedef struct packed {
    logic [lr_pkg::COORD_W-1:0]  x;
    logic [lr_pkg::COORD_W-1:0]  y;
    logic [lr_pkg::COLOUR_W-1:0] colour;
    logic                        in_plane;
    logic                        is_last;
  } pixel_t;

  // Keeps its own copy of the plane registers and the queue of pixels still owed.
  class line_tracer;
    int unsigned cap;
    int unsigned plane_w;
    int unsigned plane_h;
    pixel_t      owed[$];
    int unsigned faults;

    function new(int unsigned cap_px);
      cap     = cap_px;
      plane_w = 32'(lr_pkg::PLANE_RESET);
      plane_h = 32'(lr_pkg::PLANE_RESET);
      faults  = 0;
    endfunction

    function void set_plane(logic [lr_pkg::CFG_IDX_W-1:0] idx, logic [lr_pkg::CFG_W-1:0] val);
      if (idx == lr_pkg::CFG_PLANE_WIDTH) plane_w = 32'(val);
      else if (idx == lr_pkg::CFG_PLANE_HEIGHT) plane_h = 32'(val);
    endfunction

    function int span(int p, int q);
      return (p > q) ? p - q : q - p;
    endfunction

    // Walk the line exactly as the hardware should, endpoint included.
    function void trace_line(line_cmd_t cmd);
      int     a0, b0, a1, b1, dmaj, dmin, astep, bstep, total, a, b, err, px, py;
      bit     steep;
      pixel_t p;
      steep = span(int'(cmd.ey), int'(cmd.sy)) > span(int'(cmd.ex), int'(cmd.sx));
      a0    = steep ? int'(cmd.sy) : int'(cmd.sx);
      b0    = steep ? int'(cmd.sx) : int'(cmd.sy);
      a1    = steep ? int'(cmd.ey) : int'(cmd.ex);
      b1    = steep ? int'(cmd.ex) : int'(cmd.ey);
      dmaj  = span(a1, a0);
      dmin  = span(b1, b0);
      astep = (a0 < a1) ? 1 : -1;
      bstep = (b0 < b1) ? 1 : -1;
      total = dmaj + 1;
      if (total > int'(cap)) total = int'(cap);
      a   = a0;
      b   = b0;
      err = 0;
      for (int i = 0; i < total; i++) begin
        if (i > 0) begin
          a   += astep;
          err += dmin;
          if (2 * err > dmaj) begin
            b   += bstep;
            err -= dmaj;
          end
        end
        px         = steep ? b : a;
        py         = steep ? a : b;
        p.x        = px[lr_pkg::COORD_W-1:0];
        p.y        = py[lr_pkg::COORD_W-1:0];
        p.colour   = cmd.colour;
        p.in_plane = (32'(p.x) < plane_w) && (32'(p.y) < plane_h);
        p.is_last  = (i == total - 1);
        owed.push_back(p);
      end
    endfunction

    function void match_pixel(pixel_t got);
      pixel_t want;
      if (owed.size() == 0) begin
        faults++;
        if (faults <= 10)
          $display("%0t: unexpected pixel x=%0d y=%0d colour=%0h in=%0b last=%0b",
                   $time, got.x, got.y, got.colour, got.in_plane, got.is_last);
        return;
      end
      want = owed.pop_front();
      if (got.x != want.x || got.y != want.y || got.colour != want.colour ||
          got.in_plane != want.in_plane || got.is_last != want.is_last) begin
        faults++;
        if (faults <= 10)
          $display({"%0t: pixel mismatch exp x=%0d y=%0d colour=%0h in=%0b last=%0b, ",
                    "got x=%0d y=%0d colour=%0h in=%0b last=%0b"},
                   $time, want.x, want.y, want.colour, want.in_plane, want.is_last,
                   got.x, got.y, got.colour, got.in_plane, got.is_last);
      end
    endfunction

    function int unsigned outstanding();
      return owed.size();
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [lr_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [lr_pkg::CFG_W-1:0]      cfg_data_i;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [lr_pkg::IN_DATA_W-1:0]  s_axis_tdata;   // start_x, start_y, end_x, end_y, colour
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic [lr_pkg::OUT_DATA_W-1:0] m_axis_tdata;   // pixel_x, pixel_y, pixel_colour, pad
  logic [0:0]                    m_axis_tuser;   // in-plane flag
  logic                          m_axis_tlast;

  line_tracer  tracer = new(PIXEL_CAP);
  int unsigned cycles;
  bit          no_idle;        // both sides run back to back while set
  bit          hold_request;   // asks the receiver for one long stall

  line_rasterizer_top #(.PLANE_SIZE(PIXEL_CAP)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Cycle counter doubles as the watchdog.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_line_rasterizer_top: errors");
      $finish;
    end
  end

  // Monitor: both handshakes are sampled at the rising edge, TB drives at the falling edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        tracer.trace_line(line_cmd_t'(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready)
        tracer.match_pixel('{x:        m_axis_tdata[5:0],
                             y:        m_axis_tdata[11:6],
                             colour:   m_axis_tdata[19:12],
                             in_plane: m_axis_tuser[0],
                             is_last:  m_axis_tlast});
    end
  end

  // Pixel receiver: random stall per beat, plus one long hold-off when asked,
  // so the rasterizer backs up and drops s_axis_tready.
  initial begin
    int unsigned stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        stall        = LONG_HOLD;
        hold_request = 1'b0;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 16);
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  function automatic line_cmd_t mk_line(int sx, int sy, int ex, int ey, int colour);
    line_cmd_t c;
    c.sx     = lr_pkg::COORD_W'(sx);
    c.sy     = lr_pkg::COORD_W'(sy);
    c.ex     = lr_pkg::COORD_W'(ex);
    c.ey     = lr_pkg::COORD_W'(ey);
    c.colour = lr_pkg::COLOUR_W'(colour);
    return c;
  endfunction

  function automatic int clamp_coord(int v);
    return (v < 0) ? 0 : (v > 63) ? 63 : v;
  endfunction

  // Random line mix: arbitrary lines plus short, axis-aligned, diagonal,
  // degenerate and edge-hugging lines mixed in.
  function automatic line_cmd_t rand_line();
    int sx, sy, ex, ey, d;
    sx = $urandom_range(0, 63);
    sy = $urandom_range(0, 63);
    ex = $urandom_range(0, 63);
    ey = $urandom_range(0, 63);
    case ($urandom_range(0, 9))
      4: begin
        ex = clamp_coord(sx + $urandom_range(0, 10) - 5);
        ey = clamp_coord(sy + $urandom_range(0, 10) - 5);
      end
      5: ey = sy;
      6: ex = sx;
      7: begin
        d  = $urandom_range(0, 63);
        ex = (sx + d > 63) ? sx - d : sx + d;
        ey = (sy + d > 63) ? sy - d : sy + d;
        ex = clamp_coord(ex);
        ey = clamp_coord(ey);
        d  = (ex > sx ? ex - sx : sx - ex) < (ey > sy ? ey - sy : sy - ey) ?
             (ex > sx ? ex - sx : sx - ex) : (ey > sy ? ey - sy : sy - ey);
        ex = (ex >= sx) ? sx + d : sx - d;
        ey = (ey >= sy) ? sy + d : sy - d;
      end
      8: begin
        ex = sx;
        ey = sy;
      end
      9: begin
        sx = $urandom_range(0, 1) * 63;
        sy = $urandom_range(0, 1) * 63;
        ex = $urandom_range(0, 1) * 63;
        ey = $urandom_range(0, 1) * 63;
      end
      default: ;
    endcase
    return mk_line(sx, sy, ex, ey, $urandom_range(0, 255));
  endfunction

  // Offer one command; returns just after the rising edge that takes it.
  // Valid stays high into the next command when no gap is drawn.
  task automatic send_line(line_cmd_t cmd);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 16);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Drop valid and wait until every owed pixel is out, then let the FSM settle.
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (tracer.outstanding() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Register writes happen only with the rasterizer idle.
  task automatic write_reg(logic [lr_pkg::CFG_IDX_W-1:0] idx, logic [lr_pkg::CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    tracer.set_plane(idx, val);
  endtask

  initial begin
    logic [lr_pkg::CFG_W-1:0] widths  [6];
    logic [lr_pkg::CFG_W-1:0] heights [6];

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = lr_pkg::CFG_PLANE_WIDTH;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    no_idle       = 1'b0;
    hold_request  = 1'b0;
    cycles        = 0;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed lines at the reset plane size (64 x 64).
    send_line(mk_line(0, 0, 0, 0, 8'h00));        // equal endpoints, single pixel
    send_line(mk_line(63, 63, 63, 63, 8'hFF));
    send_line(mk_line(0, 0, 63, 63, 8'hAA));      // equal deltas, x is major
    send_line(mk_line(63, 0, 0, 63, 8'h55));
    send_line(mk_line(63, 63, 0, 0, 8'h0F));
    send_line(mk_line(0, 63, 63, 0, 8'hF0));
    send_line(mk_line(0, 0, 63, 0, 8'h01));       // horizontal, full width
    send_line(mk_line(63, 5, 0, 5, 8'h80));
    send_line(mk_line(7, 0, 7, 63, 8'h7E));       // vertical, full height
    send_line(mk_line(7, 63, 7, 0, 8'h81));
    send_line(mk_line(10, 0, 20, 63, 8'h33));     // steep
    send_line(mk_line(20, 63, 10, 0, 8'hCC));
    send_line(mk_line(0, 10, 63, 20, 8'h3C));     // shallow
    send_line(mk_line(63, 20, 0, 10, 8'hC3));
    send_line(mk_line(0, 0, 2, 1, 8'h12));        // twice the error equals the major delta
    send_line(mk_line(0, 1, 1, 3, 8'h34));
    send_line(mk_line(5, 5, 10, 3, 8'h56));
    send_line(mk_line(40, 30, 38, 31, 8'h78));
    send_line(mk_line(0, 0, 1, 0, 8'h9A));        // two-pixel lines
    send_line(mk_line(0, 0, 0, 1, 8'hBC));
    send_line(mk_line(1, 1, 0, 0, 8'hDE));
    drain();

    // Config phases: both zero (nothing inside), both max (all inside),
    // one-cell strips each way, then in-range and full-field random.
    widths[0]  = 7'd0;   heights[0] = 7'd0;
    widths[1]  = 7'd127; heights[1] = 7'd127;
    widths[2]  = 7'd1;   heights[2] = 7'd64;
    widths[3]  = 7'd64;  heights[3] = 7'd1;
    widths[4]  = lr_pkg::CFG_W'($urandom_range(1, 64));
    heights[4] = lr_pkg::CFG_W'($urandom_range(1, 64));
    widths[5]  = lr_pkg::CFG_W'($urandom_range(0, 127));
    heights[5] = lr_pkg::CFG_W'($urandom_range(0, 127));

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(lr_pkg::CFG_PLANE_WIDTH, widths[ph]);
      write_reg(lr_pkg::CFG_PLANE_HEIGHT, heights[ph]);
      no_idle = (ph == 3);   // one phase fully back to back
      for (int n = 0; n < PHASE_LINES; n++) begin
        if (ph == 1 && n == 10) hold_request = 1'b1;   // long receiver stall
        send_line(rand_line());
      end
      drain();
      no_idle = 1'b0;
    end

    repeat (16) @(posedge clk_i);
    if (tracer.faults == 0 && tracer.outstanding() == 0) begin
      $display("tb_line_rasterizer_top: clean");
    end else begin
      $display("tb_line_rasterizer_top: errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/lr_pkg.sv
design/lr_ctrl.sv
design/lr_datapath.sv
design/line_rasterizer_top.sv
design/lr_checker.sv
tb/tb_line_rasterizer_top.sv
